### hdl/lcmsd_pkg.sv
// Shared types and opcode constants for the layered cell mask store.
// No dependencies; imported by every module of the block.
`default_nettype none
package lcmsd_pkg;

	localparam logic [2:0] OP_SET_USER  = 3'd0;
	localparam logic [2:0] OP_OR_USER   = 3'd1;
	localparam logic [2:0] OP_CLR_USER  = 3'd2;
	localparam logic [2:0] OP_SET_TERR  = 3'd3;
	localparam logic [2:0] OP_SET_OBST  = 3'd4;
	localparam logic [2:0] OP_READ      = 3'd5;
	localparam logic [2:0] OP_MARK      = 3'd6;
	localparam logic [2:0] OP_CLR_DIRTY = 3'd7;

	localparam int IN_BITS  = 72;
	localparam int OUT_BITS = 88;

	// classified word waiting in the queue
	typedef struct packed {
		logic        vld;
		logic [2:0]  op;
		logic        cell_ok;
		logic [31:0] operand;
	} fe_item_t;

	// back part to front part
	typedef struct packed {
		logic pop;
		logic open;
	} bk_ctl_t;

endpackage
`default_nettype wire

### hdl/lcmsd_front.sv
// Front part: accepts input words, checks coordinates, forms the cell index
// and holds classified words in a two-entry queue. Depends on lcmsd_pkg.
`default_nettype none
module lcmsd_front #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int AW         = 12
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire [lcmsd_pkg::IN_BITS-1:0]  s_tdata,
	input  wire [6:0]                     grid_width,
	input  wire [6:0]                     grid_height,
	input  wire lcmsd_pkg::bk_ctl_t       bk_ctl,
	output lcmsd_pkg::fe_item_t           head,
	output logic [AW-1:0]                 head_idx
);
	import lcmsd_pkg::*;

	logic [2:0]  in_op;
	logic [15:0] in_x, in_y, w_eff, h_eff;
	logic [31:0] in_operand, lin;
	logic        in_ok, push;

	fe_item_t      item_q [2];
	logic [AW-1:0] idx_q  [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;

	assign in_op      = s_tdata[2:0];
	assign in_x       = s_tdata[18:3];
	assign in_y       = s_tdata[34:19];
	assign in_operand = s_tdata[66:35];

	// oversize grid registers saturate to the storage size
	assign w_eff = (16'(grid_width) > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH) : 16'(grid_width);
	assign h_eff = (16'(grid_height) > 16'(MAX_HEIGHT)) ? 16'(MAX_HEIGHT) : 16'(grid_height);
	assign in_ok = !in_x[15] && !in_y[15] && (in_x < w_eff) && (in_y < h_eff);
	assign lin   = 32'(in_y) * 32'(MAX_WIDTH) + 32'(in_x);

	assign s_tready = bk_ctl.open && (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (bk_ctl.pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(bk_ctl.pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wp_q] <= '{vld: 1'b1, op: in_op, cell_ok: in_ok, operand: in_operand};
			idx_q[wp_q]  <= in_ok ? lin[AW-1:0] : '0;
		end
	end

	always_comb begin
		head     = item_q[rp_q];
		head.vld = (cnt_q != 2'd0);
		head_idx = idx_q[rp_q];
	end

endmodule
`default_nettype wire

### hdl/lcmsd_back.sv
// Back part: cell memories, read-modify-write sequencer, dirty counters,
// clearing sweeps and the result register. Depends on lcmsd_pkg.
`default_nettype none
module lcmsd_back #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire lcmsd_pkg::fe_item_t       head,
	input  wire [AW-1:0]                   head_idx,
	output lcmsd_pkg::bk_ctl_t             bk_ctl,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [lcmsd_pkg::OUT_BITS-1:0] m_tdata
);
	import lcmsd_pkg::*;

	localparam logic [1:0] ST_INIT = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;
	localparam logic [1:0] ST_CLR  = 2'd3;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [1:0]    state_q;
	logic [AW-1:0] sweep_q;

	logic [95:0]   layer_mem [DEPTH];
	logic          dirty_mem [DEPTH];
	logic [95:0]   layer_rd_q;
	logic          dirty_rd_q;

	logic [2:0]    op_q;
	logic          ok_q;
	logic [AW-1:0] idx_q;
	logic [31:0]   operand_q;

	logic [12:0]   count_q;
	logic [31:0]   rev_q;

	logic          m_tvalid_q;
	logic [31:0]   o_comp_q, o_rev_q;
	logic          o_valid_q, o_dirty_q, o_pass_q, o_fresh_q;
	logic [12:0]   o_count_q;

	logic        fire, is_write, lay_chg, fresh_n, dirty_n;
	logic [31:0] u, t, o, u_n, t_n, o_n, comp_old, comp_n;

	assign bk_ctl.pop  = (state_q == ST_IDLE) && head.vld;
	assign bk_ctl.open = (state_q != ST_INIT);
	assign fire        = (state_q == ST_EXEC) && (!m_tvalid_q || m_tready);

	assign u = layer_rd_q[31:0];
	assign t = layer_rd_q[63:32];
	assign o = layer_rd_q[95:64];
	assign comp_old = u | t | o;

	always_comb begin
		u_n = u;
		t_n = t;
		o_n = o;
		is_write = 1'b0;
		unique case (op_q)
			OP_SET_USER:  begin u_n = operand_q;       is_write = 1'b1; end
			OP_OR_USER:   begin u_n = u | operand_q;   is_write = 1'b1; end
			OP_CLR_USER:  begin u_n = u & ~operand_q;  is_write = 1'b1; end
			OP_SET_TERR:  begin t_n = operand_q;       is_write = 1'b1; end
			OP_SET_OBST:  begin o_n = operand_q;       is_write = 1'b1; end
			default: ;
		endcase
		lay_chg = (u_n != u) || (t_n != t) || (o_n != o);
		comp_n  = u_n | t_n | o_n;
		fresh_n = 1'b0;
		if (ok_q && !dirty_rd_q) begin
			if (op_q == OP_MARK)
				fresh_n = 1'b1;
			else if (is_write && lay_chg && (comp_n != comp_old))
				fresh_n = 1'b1;
		end
		dirty_n = (op_q == OP_CLR_DIRTY) ? 1'b0 : (dirty_rd_q | fresh_n);
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			sweep_q <= '0;
			count_q <= '0;
			rev_q   <= '0;
		end else begin
			unique case (state_q)
				ST_INIT, ST_CLR: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == LAST) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head.vld)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (fire) begin
						if (op_q == OP_CLR_DIRTY) begin
							count_q <= '0;
							state_q <= ST_CLR;
						end else begin
							state_q <= ST_IDLE;
							if (fresh_n)
								count_q <= count_q + 13'd1;
						end
						if (fresh_n)
							rev_q <= rev_q + 32'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// word held for execution
	always_ff @(posedge clk) begin
		if (bk_ctl.pop) begin
			op_q      <= head.op;
			ok_q      <= head.cell_ok;
			idx_q     <= head_idx;
			operand_q <= head.operand;
		end
	end

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (state_q == ST_INIT)
			layer_mem[sweep_q] <= '0;
		else if (fire && ok_q && is_write)
			layer_mem[idx_q] <= {o_n, t_n, u_n};
		if (bk_ctl.pop)
			layer_rd_q <= layer_mem[head_idx];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_INIT || state_q == ST_CLR)
			dirty_mem[sweep_q] <= 1'b0;
		else if (fire && fresh_n)
			dirty_mem[idx_q] <= 1'b1;
		if (bk_ctl.pop)
			dirty_rd_q <= dirty_mem[head_idx];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (fire)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			o_comp_q  <= ok_q ? comp_n : 32'd0;
			o_valid_q <= ok_q;
			o_dirty_q <= ok_q && dirty_n;
			o_pass_q  <= ok_q && ((comp_n & operand_q) == 32'd0);
			o_fresh_q <= fresh_n;
			o_count_q <= (op_q == OP_CLR_DIRTY) ? 13'd0 : (count_q + 13'(fresh_n));
			o_rev_q   <= rev_q + 32'(fresh_n);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, o_rev_q, o_count_q, o_fresh_q, o_pass_q, o_dirty_q,
		o_valid_q, o_comp_q};

	a_fresh_needs_cell: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && o_fresh_q |-> o_valid_q && o_dirty_q)
		else $error("newly dirtied result on an invalid or clean cell");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && !o_valid_q |-> o_comp_q == 32'd0 && !o_pass_q && !o_dirty_q)
		else $error("invalid cell reports non-zero fields");
	a_rev_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && fresh_n |=> rev_q == $past(rev_q) + 32'd1)
		else $error("revision did not advance on a new dirty mark");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		bk_ctl.pop |-> state_q == ST_IDLE)
		else $error("queue popped while busy");

endmodule
`default_nettype wire

### hdl/layered_cell_mask_store_dirty_track.sv
// Top level of the layered cell mask store: APB register file and stream ports.
// Depends on lcmsd_pkg, lcmsd_front and lcmsd_back.
`default_nettype none
// Each cell of a MAX_WIDTH x MAX_HEIGHT grid holds user, terrain and obstruction
// masks; one input word runs one opcode on one cell and gives one result word.
// After reset the block sweeps the whole store clean, one cell a cycle, over
// all MAX_WIDTH*MAX_HEIGHT cells, and takes no input word until that is done.
// A normal word passes through the back part as a memory read, then
// modify/write/result, set by the registered read-modify-write of the cell
// memory; a clear-all word adds a sweep of the dirty bitmap over all cells.
// A two-word queue lets the input side keep accepting while the back part
// works. A single result register holds the finished word; the back part waits
// in its modify/write/result step while that register is full and not taken.
// grid_width lives at byte address 0 and grid_height at 4; values above the
// storage size act as the storage size. Write them only while idle.
module layered_cell_mask_store_dirty_track #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	// opcode[2:0], cell_x[18:3], cell_y[34:19], operand_value[66:35], zero pad
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [71:0]  s_tdata,
	// composed_mask[31:0], cell_valid[32], cell_dirty[33], passable[34],
	// newly_dirtied[35], dirty_count[48:36], revision[80:49], zero pad
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [87:0] m_tdata,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire [2:0]   paddr,
	input  wire [31:0]  pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lcmsd_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [6:0]    gw_q, gh_q;
	logic          wr_en;
	fe_item_t      head;
	logic [AW-1:0] head_idx;
	bk_ctl_t       bk_ctl;

	// register file: word-aligned, bit 2 picks the register
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= 7'd64;
			gh_q <= 7'd64;
		end else if (wr_en) begin
			if (paddr[2])
				gh_q <= pwdata[6:0];
			else
				gw_q <= pwdata[6:0];
		end
	end

	assign prdata = paddr[2] ? {25'd0, gh_q} : {25'd0, gw_q};

	lcmsd_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.AW        (AW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.grid_width (gw_q),
		.grid_height(gh_q),
		.bk_ctl     (bk_ctl),
		.head       (head),
		.head_idx   (head_idx)
	);

	lcmsd_back #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.head_idx(head_idx),
		.bk_ctl  (bk_ctl),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule
`default_nettype wire

### sim/tb_layered_cell_mask_store_dirty_track.sv
// Self-checking testbench for the layered cell mask store with dirty tracking.
// Depends on lcmsd_pkg and layered_cell_mask_store_dirty_track, which brings in lcmsd_front and lcmsd_back.
`default_nettype none
module tb_layered_cell_mask_store_dirty_track;
	import lcmsd_pkg::*;

	localparam int GRID_MAX  = 64;
	localparam int CELLS     = GRID_MAX * GRID_MAX;
	localparam int REG_WIDTH  = 0;
	localparam int REG_HEIGHT = 1;
	localparam int STALL_LIMIT = 40000;	// covers the reset sweep and a clear-all sweep

	// idling phases
	typedef enum int {PH_NONE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH} phase_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] x;
		logic [15:0] y;
		logic [31:0] operand;
	} cmd_word_t;

	// highest field first, so the packing matches m_tdata
	typedef struct packed {
		logic [31:0] revision;
		logic [12:0] count;
		logic        fresh;
		logic        passable;
		logic        dirty;
		logic        valid;
		logic [31:0] composed;
	} cell_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [71:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	layered_cell_mask_store_dirty_track u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted store state
	logic [31:0] user_m [CELLS];
	logic [31:0] terr_m [CELLS];
	logic [31:0] obst_m [CELLS];
	logic        dirty_m [CELLS];
	logic [12:0] dirty_cnt;
	logic [31:0] rev_cnt;
	logic [6:0]  width_reg, height_reg;

	cmd_word_t    word_queue [$];
	cell_result_t result_queue [$];
	phase_t phase = PH_NONE;
	int  hold_off = 0;
	int  errors = 0, sent = 0, received = 0, idle_cycles = 0;
	bit  timed_out = 0;

	function automatic bit mark_cell(int i);
		if (dirty_m[i])
			return 1'b0;
		dirty_m[i] = 1'b1;
		dirty_cnt++;
		rev_cnt++;
		return 1'b1;
	endfunction

	// apply one command to the predicted store and give its result
	function automatic cell_result_t cell_apply(cmd_word_t c);
		cell_result_t r;
		int w, h, xi, yi, i;
		logic [31:0] nv, was;
		bit ok, fresh;
		w = (width_reg > GRID_MAX) ? GRID_MAX : width_reg;
		h = (height_reg > GRID_MAX) ? GRID_MAX : height_reg;
		xi = $signed(c.x);
		yi = $signed(c.y);
		ok = xi >= 0 && yi >= 0 && xi < w && yi < h;
		i = ok ? yi * GRID_MAX + xi : 0;
		fresh = 1'b0;
		if (c.op == OP_CLR_DIRTY) begin
			foreach (dirty_m[k]) dirty_m[k] = 1'b0;
			dirty_cnt = '0;
		end else if (ok) begin
			was = user_m[i] | terr_m[i] | obst_m[i];
			case (c.op)
				OP_SET_USER, OP_OR_USER, OP_CLR_USER: begin
					nv = (c.op == OP_SET_USER) ? c.operand :
						(c.op == OP_OR_USER) ? (user_m[i] | c.operand) :
						(user_m[i] & ~c.operand);
					if (nv != user_m[i]) begin
						user_m[i] = nv;
						if (was != (user_m[i] | terr_m[i] | obst_m[i])) fresh = mark_cell(i);
					end
				end
				OP_SET_TERR: if (c.operand != terr_m[i]) begin
					terr_m[i] = c.operand;
					if (was != (user_m[i] | terr_m[i] | obst_m[i])) fresh = mark_cell(i);
				end
				OP_SET_OBST: if (c.operand != obst_m[i]) begin
					obst_m[i] = c.operand;
					if (was != (user_m[i] | terr_m[i] | obst_m[i])) fresh = mark_cell(i);
				end
				OP_MARK: fresh = mark_cell(i);
				default: ;
			endcase
		end
		r.composed = ok ? (user_m[i] | terr_m[i] | obst_m[i]) : '0;
		r.valid = ok;
		r.dirty = ok ? dirty_m[i] : 1'b0;
		r.passable = ok && ((r.composed & c.operand) == '0);
		r.fresh = fresh;
		r.count = dirty_cnt;
		r.revision = rev_cnt;
		return r;
	endfunction

	// sender: one word in flight on the slave side
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				result_queue = {result_queue, cell_apply(word_queue.pop_front())};
				sent++;
			end
			if (word_queue.size() != 0 &&
					!((phase == PH_SRC_IDLE || phase == PH_BOTH) && $urandom_range(99) < 83)) begin
				cmd_word_t c;
				c = word_queue[0];
				s_tvalid <= 1'b1;
				s_tdata <= {5'd0, c.operand, c.y, c.x, c.op};
			end else if (!s_tvalid || s_tready) begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				cell_result_t got, want;
				got = m_tdata[80:0];
				received++;
				if (result_queue.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, expected none actual %h", $time, got);
				end else begin
					want = result_queue.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: mismatch expected %h actual %h", $time, want, got);
					end
				end
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !((phase == PH_SNK_STALL || phase == PH_BOTH) &&
					$urandom_range(99) < 83);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("tb_layered_cell_mask_store_dirty_track NOT OK");
			$finish;
		end
	end

	task automatic reg_write(int idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(idx * 4); pwdata <= v; penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_WIDTH) width_reg = v[6:0];
		else height_reg = v[6:0];
	endtask

	task automatic drain();
		wait (word_queue.size() == 0 && !s_tvalid);
		wait (result_queue.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic push(logic [2:0] op, int x, int y, logic [31:0] v);
		cmd_word_t c;
		c.op = op; c.x = 16'(x); c.y = 16'(y); c.operand = v;
		word_queue = {word_queue, c};
	endtask

	// mostly in-grid coordinates, sometimes anywhere in the 16-bit range
	function automatic int coord(int lim);
		if ($urandom_range(9) == 0)
			return $signed(16'($urandom()));
		return $urandom_range(lim > 0 ? lim - 1 : 0);
	endfunction

	task automatic random_burst(int n, int w, int h);
		logic [2:0] op;
		logic [31:0] v;
		repeat (n) begin
			op = ($urandom_range(99) < 3) ? OP_CLR_DIRTY : 3'($urandom_range(6));
			case ($urandom_range(3))
				0: v = '0;
				1: v = '1;
				2: v = 32'(1) << $urandom_range(31);
				default: v = $urandom();
			endcase
			push(op, coord(w + 1), coord(h + 1), v);
		end
	endtask

	initial begin
		foreach (user_m[k]) begin
			user_m[k] = '0; terr_m[k] = '0; obst_m[k] = '0; dirty_m[k] = 1'b0;
		end
		dirty_cnt = '0; rev_cnt = '0; width_reg = 7'd64; height_reg = 7'd64;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every opcode, grid corners, negative and far coordinates
		push(OP_SET_USER, 0, 0, 32'hFFFF_FFFF);
		push(OP_SET_USER, 0, 0, 32'hFFFF_FFFF);	// unchanged layer
		push(OP_SET_TERR, 0, 0, 32'h0000_00FF);	// composed unchanged
		push(OP_OR_USER, 63, 63, 32'h8000_0001);
		push(OP_CLR_USER, 63, 63, 32'h0000_0001);
		push(OP_SET_OBST, 63, 0, 32'h1234_5678);
		push(OP_READ, 63, 0, 32'h0000_0008);
		push(OP_READ, 63, 0, 32'h0000_0001);
		push(OP_MARK, 0, 63, 32'h0);	// mark without value change
		push(OP_MARK, 0, 63, 32'h0);
		push(OP_SET_USER, -1, 0, 32'h1);
		push(OP_SET_USER, 64, 5, 32'h1);
		push(OP_READ, 32767, -32768, 32'h1);
		push(OP_MARK, -32768, 32767, 32'h1);
		push(OP_CLR_DIRTY, -5, 200, 32'h0);	// clear-all from outside the grid
		push(OP_READ, 0, 0, 32'h0);
		push(OP_SET_USER, 0, 0, 32'h0);
		drain();

		// width 0 and height oversize, then narrow grid; outside flags still count
		reg_write(REG_WIDTH, 0);
		reg_write(REG_HEIGHT, 127);
		push(OP_SET_USER, 0, 0, 32'h5);
		push(OP_READ, 0, 100, 32'h5);
		drain();
		reg_write(REG_WIDTH, 4);
		reg_write(REG_HEIGHT, 3);
		random_burst(150, 4, 3);
		drain();

		reg_write(REG_WIDTH, 64);
		reg_write(REG_HEIGHT, 64);
		phase = PH_NONE;      random_burst(150, 64, 64); drain();
		phase = PH_SRC_IDLE;  random_burst(150, 8, 8);   drain();
		phase = PH_SNK_STALL; random_burst(150, 8, 64);  drain();
		phase = PH_BOTH;      random_burst(150, 64, 8);  drain();

		// long receiver hold-off while words keep coming, filling the block
		phase = PH_NONE;
		reg_write(REG_WIDTH, 1);
		reg_write(REG_HEIGHT, 1);
		hold_off = 300;
		random_burst(100, 1, 1);
		drain();

		$display("covered %0d words through all opcodes, grid sizes 0 to oversize,",
			sent);
		$display("idling phases and a long output stall; %0d errors", errors);
		if (errors == 0)
			$display("tb_layered_cell_mask_store_dirty_track OK");
		else
			$display("tb_layered_cell_mask_store_dirty_track NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
